// ===== rtl/polyblep_oscillator_macros.svh =====
// Assertion macros for the band-limited oscillator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POLYBLEP_OSCILLATOR_MACROS_SVH
`define POLYBLEP_OSCILLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define PBO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante.
`define PBO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define PBO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/pbo_pkg.sv =====
// Shared types, constants and the sine table builder for the oscillator.
// No dependencies; every RTL module and interface imports it.
package pbo_pkg;

  // Field widths
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned WAVE_W     = 3;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SINE_MAG_W = 15;
  localparam int unsigned ACC_W      = 36;
  localparam int unsigned Q15_SHIFT  = 17;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_PHASE_BITS       = 32;
  localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;

  // Divider: two quotient bits per cycle over a 32-bit quotient
  localparam int unsigned DIV_RADIX_BITS = 2;
  localparam int unsigned DIV_CYCLES     = FRAC_W / DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_CYCLES);

  localparam logic [FRAC_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam longint unsigned   TWO_PI_Q30 = 64'd6746518852;

  // Waveform codes; anything else is silence
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_PSEL,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } pbo_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic base;
    logic pass;
    logic div_start;
    logic mul;
    logic acc;
    logic out_load;
  } pbo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] pass_cnt;
    logic       blep_hit;
    logic       div_busy;
    logic       out_full;
  } pbo_status_t;

  // Sine magnitude in Q15 for a first-quadrant angle x (Q0.32 turn, x <= 2^30).
  // Taylor series to the a^13 term, evaluated at elaboration only.
  function automatic logic [SINE_MAG_W-1:0] pbo_sine_mag(input longint unsigned x);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    longint unsigned m;
    a    = (x * TWO_PI_Q30) >> 32;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    m = (longint'(sum) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return SINE_MAG_W'(m);
  endfunction

endpackage

// ===== rtl/pbo_if.sv =====
// Valid/ready channel interfaces for the oscillator: input, output, config.
// Depends on pbo_pkg for field widths.
interface pbo_in_if;
  import pbo_pkg::*;
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] phase_increment;
  logic              restart;
  modport source (output valid, output phase_increment, output restart, input ready);
  modport sink   (input valid, input phase_increment, input restart, output ready);
endinterface

interface pbo_out_if;
  import pbo_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pbo_cfg_if;
  import pbo_pkg::*;
  logic              valid;
  logic              ready;
  logic [WAVE_W-1:0] waveform;
  modport source (output valid, output waveform, input ready);
  modport sink   (input valid, input waveform, output ready);
endinterface

// ===== rtl/pbo_divider.sv =====
// Iterative unsigned divider: quotient of (num << 32) / den with num < den.
// Two restoring steps per cycle. Depends on pbo_pkg.
`include "polyblep_oscillator_macros.svh"
module pbo_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [pbo_pkg::FRAC_W-1:0] num_i,
  input  logic [pbo_pkg::FRAC_W-1:0] den_i,
  output logic                  busy_o,
  output logic [pbo_pkg::FRAC_W-1:0] quot_o
);
  import pbo_pkg::*;

  logic [FRAC_W-1:0]    rem_q, rem_d;
  logic [FRAC_W-1:0]    den_q;
  logic [FRAC_W-1:0]    quot_q, quot_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;

  // Shift in zeros and subtract, DIV_RADIX_BITS times
  always_comb begin
    logic [FRAC_W:0] r2;
    rem_d  = rem_q;
    quot_d = quot_q;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      r2 = {rem_d, 1'b0};
      if (r2 >= {1'b0, den_q}) begin
        rem_d  = FRAC_W'(r2 - {1'b0, den_q});
        quot_d = {quot_d[FRAC_W-2:0], 1'b1};
      end else begin
        rem_d  = r2[FRAC_W-1:0];
        quot_d = {quot_d[FRAC_W-2:0], 1'b0};
      end
    end
  end

  // Control: count iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  `PBO_ASSERT_SAME(a_rem_below_den, clk_i, rst_ni, busy_q, rem_q < den_q,
                   "divider remainder not below divisor")
  `PBO_ASSERT_SAME(a_div_length, clk_i, rst_ni, $fell(busy_q),
                   $past(start_i, DIV_CYCLES + 1), "divider finished at the wrong time")

endmodule

// ===== rtl/pbo_ctrl.sv =====
// Sequencer for one sample: base value, up to two PolyBLEP passes, output.
// Depends on pbo_pkg for state, command and status types.
`include "polyblep_oscillator_macros.svh"
module pbo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pbo_pkg::pbo_status_t status_i,
  output pbo_pkg::pbo_cmd_t    cmd_o
);
  import pbo_pkg::*;

  pbo_state_e state_q, state_d;
  logic       pass_q, pass_d;
  logic       pass_last;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  assign pass_last = (2'({1'b0, pass_q}) + 2'd1) >= status_i.pass_cnt;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    cmd_o.pass = pass_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        pass_d     = 1'b0;
        state_d    = (status_i.pass_cnt != 2'd0) ? ST_PSEL : ST_DONE;
      end
      ST_PSEL: begin
        if (status_i.blep_hit) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (pass_last) begin
          state_d = ST_DONE;
        end else begin
          pass_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (pass_last) begin
          state_d = ST_DONE;
        end else begin
          pass_d  = 1'b1;
          state_d = ST_PSEL;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the sample
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `PBO_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load, !status_i.out_full,
                   "sample loaded over an unread result")
  `PBO_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, cmd_o.div_start, status_i.div_busy,
                   "divider did not start")

endmodule

// ===== rtl/pbo_datapath.sv =====
// Phase accumulator, waveform arithmetic, sine table, PolyBLEP accumulation
// and output register. Depends on pbo_pkg and pbo_divider.
`include "polyblep_oscillator_macros.svh"
module pbo_datapath #(
  parameter int unsigned PHASE_BITS       = pbo_pkg::DEF_PHASE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = pbo_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [pbo_pkg::WAVE_W-1:0]          waveform_i,
  input  logic [pbo_pkg::FRAC_W-1:0]          in_inc_i,
  input  logic                                in_restart_i,
  input  logic                                out_ready_i,
  input  pbo_pkg::pbo_cmd_t                   cmd_i,
  output pbo_pkg::pbo_status_t                status_o,
  output logic                                out_valid_o,
  output logic signed [pbo_pkg::SAMPLE_W-1:0] out_sample_o
);
  import pbo_pkg::*;

  localparam int unsigned LOG2D     = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QTR_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QTR_AW    = LOG2D - 1;

  localparam logic signed [ACC_W-1:0] ACC_ONE  = {{(ACC_W-33){1'b0}}, 1'b1, 32'd0};
  localparam logic signed [ACC_W-1:0] RND_BIAS = {{(ACC_W-17){1'b0}}, 1'b1, 16'd0};
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

  // Phase and per-item operands
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS-1:0] base_phase;
  logic [PHASE_BITS-1:0] inc_ext;
  logic [FRAC_W-1:0]     t_view;
  logic [FRAC_W-1:0]     dt_sat;
  logic [FRAC_W-1:0]     t_q;
  logic [FRAC_W-1:0]     dt_q;

  assign dt_sat     = (in_inc_i > HALF_TURN) ? HALF_TURN : in_inc_i;
  assign base_phase = in_restart_i ? '0 : phase_q;

  // Align the phase to a 32-bit turn and the increment to the phase width
  if (PHASE_BITS == FRAC_W) begin : g_phase_eq
    assign t_view  = base_phase;
    assign inc_ext = dt_sat;
  end else if (PHASE_BITS > FRAC_W) begin : g_phase_wide
    assign t_view  = base_phase[PHASE_BITS-1 -: FRAC_W];
    assign inc_ext = {dt_sat, {(PHASE_BITS-FRAC_W){1'b0}}};
  end else begin : g_phase_narrow
    assign t_view  = {base_phase, {(FRAC_W-PHASE_BITS){1'b0}}};
    assign inc_ext = dt_sat[FRAC_W-1 -: PHASE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.load) begin
      phase_q <= base_phase + inc_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q  <= t_view;
      dt_q <= dt_sat;
    end
  end

  // Quarter-wave sine table, entries 0..QTR_DEPTH
  logic [SINE_MAG_W-1:0] sine_lut [QTR_DEPTH+1];
  for (genvar k = 0; k <= QTR_DEPTH; k++) begin : g_lut
    assign sine_lut[k] = pbo_sine_mag(64'(k) << (FRAC_W - LOG2D));
  end

  logic [LOG2D-1:0]      sine_idx;
  logic [1:0]            sine_quad;
  logic [QTR_AW-1:0]     sine_addr;
  logic [SINE_MAG_W-1:0] rom_q;
  logic                  neg_q;
  logic signed [SAMPLE_W-1:0] sine_val;

  assign sine_idx  = t_q[FRAC_W-1 -: LOG2D];
  assign sine_quad = sine_idx[LOG2D-1 -: 2];
  assign sine_addr = sine_quad[0] ? (QTR_AW'(QTR_DEPTH) - {1'b0, sine_idx[LOG2D-3:0]})
                                  : {1'b0, sine_idx[LOG2D-3:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      rom_q <= sine_lut[sine_addr];
      neg_q <= sine_quad[1];
    end
  end

  assign sine_val = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  // Region test for the current pass; the second pass is shifted half a turn
  logic [FRAC_W-1:0] tk;
  logic [FRAC_W:0]   one_minus_dt;
  logic              near_lo, near_hi;
  logic [FRAC_W-1:0] div_num;
  logic              div_busy;
  logic [FRAC_W-1:0] quot;
  logic              mode_w_q;

  assign tk           = {t_q[FRAC_W-1] ^ cmd_i.pass, t_q[FRAC_W-2:0]};
  assign one_minus_dt = {1'b1, {FRAC_W{1'b0}}} - {1'b0, dt_q};
  assign near_lo      = tk < dt_q;
  assign near_hi      = {1'b0, tk} > one_minus_dt;
  assign div_num      = near_lo ? tk : (FRAC_W'(0) - tk);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      mode_w_q <= !near_lo;
    end
  end

  pbo_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (dt_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // Square of the quotient
  logic [2*FRAC_W-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= quot * quot;
    end
  end

  // Base waveform value and correction terms, all signed Q32
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] saw_base;
  logic signed [ACC_W-1:0] tri_abs;
  logic signed [ACC_W-1:0] base_val;
  logic signed [ACC_W-1:0] q_ext;
  logic signed [ACC_W-1:0] hi_ext;
  logic signed [ACC_W-1:0] blep;
  logic                    blep_sub;

  assign saw_base = $signed({{(ACC_W-FRAC_W-1){1'b0}}, t_q, 1'b0}) - ACC_ONE;
  assign tri_abs  = saw_base[ACC_W-1] ? -saw_base : saw_base;

  always_comb begin
    unique case (waveform_i)
      WAVE_SAW:      base_val = saw_base;
      WAVE_SQUARE:   base_val = t_q[FRAC_W-1] ? -ACC_ONE : ACC_ONE;
      WAVE_TRIANGLE: base_val = (tri_abs <<< 1) - ACC_ONE;
      default:       base_val = '0;
    endcase
  end

  assign q_ext    = $signed({{(ACC_W-FRAC_W){1'b0}}, quot});
  assign hi_ext   = $signed({{(ACC_W-FRAC_W){1'b0}}, prod_q[2*FRAC_W-1 -: FRAC_W]});
  assign blep     = mode_w_q ? (hi_ext - (q_ext <<< 1) + ACC_ONE)
                             : ((q_ext <<< 1) - hi_ext - ACC_ONE);
  assign blep_sub = (waveform_i == WAVE_SAW) || cmd_i.pass;

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      acc_q <= base_val;
    end else if (cmd_i.acc) begin
      acc_q <= blep_sub ? (acc_q - blep) : (acc_q + blep);
    end
  end

  // Round half up to Q15 and saturate
  logic signed [ACC_W-1:0]    rnd;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic signed [SAMPLE_W-1:0] sample_d;

  assign rnd = (acc_q + RND_BIAS) >>> Q15_SHIFT;

  always_comb begin
    if (rnd > SAT_HI) begin
      sat_val = SAMPLE_W'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      sat_val = SAMPLE_W'(SAT_LO);
    end else begin
      sat_val = SAMPLE_W'(rnd);
    end
  end

  assign sample_d = (waveform_i == WAVE_SINE) ? sine_val : sat_val;

  // Output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = sample_q;

  // Status back to the controller
  always_comb begin
    unique case (waveform_i)
      WAVE_SAW:    status_o.pass_cnt = 2'd1;
      WAVE_SQUARE: status_o.pass_cnt = 2'd2;
      default:     status_o.pass_cnt = 2'd0;
    endcase
    status_o.blep_hit = near_lo || near_hi;
    status_o.div_busy = div_busy;
    status_o.out_full = out_valid_q && !out_ready_i;
  end

  `PBO_ASSERT_SAME(a_div_nonzero, clk_i, rst_ni, cmd_i.div_start, dt_q != '0,
                   "division started with a zero increment")

endmodule

// ===== rtl/polyblep_oscillator.sv =====
// Band-limited oscillator top level: waveform register, controller, datapath.
// Depends on pbo_pkg, the channel interfaces, pbo_ctrl and pbo_datapath.
//
// Use: write the 3-bit waveform code on the config channel (0 saw, 1 square,
// 2 sine, 3 triangle, 4..7 silence) while the block is idle; it is always
// ready. Each beat on the input channel carries one phase increment (unsigned
// Q0.32, clamped to one half) and a restart flag, and yields exactly one
// signed Q1.15 sample beat on the output channel, computed from the phase
// before it advances.
// An input beat is loaded and its base value formed; sine, triangle and
// silence then go to the output stage, a saw tests one edge and a
// square two. Each corrected edge runs through the shared divider, which
// resolves two quotient bits per cycle, then is squared and accumulated.
// The next input beat is taken the cycle after the sample enters the output
// register; a new item is not taken while the last one is being computed.
// Reset clears the phase, the waveform code (saw), output valid and state.
// When the receiver stalls, the finished sample waits in the output
// register; the next item is still accepted and is held before its output
// until that register drains.
module polyblep_oscillator #(
  parameter int unsigned PHASE_BITS       = pbo_pkg::DEF_PHASE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = pbo_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbo_cfg_if.sink   cfg_ch,
  pbo_in_if.sink    in_ch,
  pbo_out_if.source out_ch
);
  import pbo_pkg::*;

  logic [WAVE_W-1:0] waveform_q;
  pbo_cmd_t          cmd;
  pbo_status_t       status;

  // Config register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= WAVE_SAW;
    end else if (cfg_ch.valid) begin
      waveform_q <= cfg_ch.waveform;
    end
  end

  pbo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbo_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .waveform_i   (waveform_q),
    .in_inc_i     (in_ch.phase_increment),
    .in_restart_i (in_ch.restart),
    .out_ready_i  (out_ch.ready),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_ch.valid),
    .out_sample_o (out_ch.sample)
  );

endmodule
